[design/pta_pkg.sv]
// Package: types and constants shared by the peer table design.
`default_nettype none
package pta_pkg;
  localparam int MaxPeers = 8;
  localparam int IdxW = 3;
  localparam int CntW = 4;
  localparam logic [7:0] PacketBytes = 8'd24;

  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam logic [15:0] LongPressReset = 16'd500;

  localparam logic [1:0] REQ_PKT = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_BTN = 2'd2;

  localparam logic [7:0] KIND_ANNOUNCE = 8'd0;
  localparam logic [7:0] KIND_ACK = 8'd2;

  localparam logic [1:0] CMD_FLIP = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  typedef enum logic [3:0] {
    EV_NONE = 4'd0,
    EV_BAD_LEN = 4'd1,
    EV_NEW = 4'd2,
    EV_REFRESH = 4'd3,
    EV_ACK = 4'd4,
    EV_FULL = 4'd5,
    EV_PURGED = 4'd6,
    EV_SEL_NEXT = 4'd7,
    EV_CMD = 4'd8
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PURGE,
    ST_LEVEL,
    ST_OUT
  } state_t;

  // Level compare request to the pta_level unit.
  typedef struct packed {
    logic [31:0] age;
    logic [15:0] tmo;
  } lvl_req_t;
endpackage
`default_nettype wire

[design/peer_table_with_aging_core.sv]
// Top level: peer table with aging, selection and button handling.
// Usage: one item enters on the in_ channel; exactly one result leaves on
// the out_ channel. in_tready is high only while the block is idle with no
// result pending. A packet scans the table one entry per cycle (up to 8),
// a tick walks all entries top down one per cycle, removing stale ones and
// shifting the rest down, a button sample takes no scan. The ST_OUT state
// registers the result with the selected peer's level, then the result sits
// in the output register until out_tready. The next item is taken in the cycle
// after the result beat. Configuration beats on cfg_ are always ready and must
// only come while idle. Reset (rst_n low, synchronous) empties the table,
// clears the selection to -1, releases the button and loads timeout 5000 ms
// and long press 500 ms. A stalled receiver holds the result and blocks new
// items.
`default_nettype none
module peer_table_with_aging_core
  import pta_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata: now_ms[31:0], peer_mac[79:32], pkt_len[87:80], pkt_kind[95:88],
  // payload[127:96], pressed[128], zero fill to 136
  input  wire  [135:0] in_tdata,
  // tuser: req_type[1:0]
  input  wire  [1:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata: event_res[3:0], cmd_send[4], cmd_mac[52:5], cmd_code[54:53],
  // selected_index[58:55], peer_count[62:59], purged_count[66:63],
  // sel_gate_up[67], sel_acked[68], sel_signal_level[71:69]
  output logic [71:0]  out_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [0:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  logic [47:0] addr_mem [MaxPeers];
  logic [31:0] seen_mem [MaxPeers];
  logic [31:0] gate_mem [MaxPeers];
  logic        ack_mem  [MaxPeers];

  state_t state_r, state_nxt;
  logic [CntW-1:0] total_r, total_nxt;
  logic signed [3:0] pick_r, pick_nxt;
  logic btn_r, btn_nxt;
  logic [31:0] press_r, press_nxt;
  logic [15:0] tmo_r, lp_r;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic [CntW-1:0] purged_r, purged_nxt;
  event_t ev_r, ev_nxt;
  logic send_r, send_nxt;
  logic [47:0] cmac_r, cmac_nxt;
  logic [1:0] req_r;
  logic [31:0] now_r;
  logic [47:0] mac_r;
  logic [7:0] len_r, kind_r;
  logic [31:0] pay_r;
  logic pr_r;
  logic [71:0] out_r;
  logic out_v_r;

  logic [IdxW-1:0] pidx;
  logic [IdxW-1:0] didx;
  logic [IdxW-1:0] sidx;
  logic sel_ok;
  logic stale;
  logic [2:0] level;
  lvl_req_t lreq;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [47:0] wr_addr;
  logic [31:0] wr_seen, wr_gate;
  logic wr_ack;
  logic sh_en;
  logic [31:0] held;
  logic accept;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;
  assign pidx = ptr_r[IdxW-1:0];
  assign didx = pidx - 1'b1;
  assign sidx = pick_r[IdxW-1:0];
  assign sel_ok = !pick_r[3] && ({1'b0, pick_r[2:0]} < total_r);
  assign stale = (now_r - seen_mem[didx]) > {16'd0, tmo_r};
  assign held = now_r - press_r;
  assign lreq = '{age: now_r - seen_mem[sidx], tmo: tmo_r};

  pta_level u_level (.req(lreq), .level(level));

  // Hold input beat and config registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_tuser;
      now_r <= in_tdata[31:0];
      mac_r <= in_tdata[79:32];
      len_r <= in_tdata[87:80];
      kind_r <= in_tdata[95:88];
      pay_r <= in_tdata[127:96];
      pr_r <= in_tdata[128];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TimeoutReset;
      lp_r <= LongPressReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index[0])
        CFG_TIMEOUT: tmo_r <= cfg_data;
        CFG_LONG_PRESS: lp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table write port and compaction shift
  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_addr;
      seen_mem[wr_idx] <= wr_seen;
      gate_mem[wr_idx] <= wr_gate;
      ack_mem[wr_idx] <= wr_ack;
    end
    if (sh_en) begin
      for (int j = 0; j < MaxPeers - 1; j++) begin
        if (CntW'(j + 1) >= ptr_r && CntW'(j + 1) < total_r) begin
          addr_mem[j] <= addr_mem[j+1];
          seen_mem[j] <= seen_mem[j+1];
          gate_mem[j] <= gate_mem[j+1];
          ack_mem[j] <= ack_mem[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      pick_r <= -4'sd1;
      btn_r <= 1'b0;
      press_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      pick_r <= pick_nxt;
      btn_r <= btn_nxt;
      press_r <= press_nxt;
      if (state_r == ST_OUT) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    purged_r <= purged_nxt;
    ev_r <= ev_nxt;
    send_r <= send_nxt;
    cmac_r <= cmac_nxt;
    if (state_r == ST_OUT) begin
      out_r <= {(sel_ok ? level : 3'd0),
                sel_ok && ack_mem[sidx],
                sel_ok && (gate_mem[sidx] == 32'd1),
                purged_r, total_r, pick_r,
                (send_r ? CMD_FLIP : 2'd0), cmac_r, send_r, ev_r};
    end
  end

  // Sequencer: scan, purge walk, result
  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    pick_nxt = pick_r;
    btn_nxt = btn_r;
    press_nxt = press_r;
    ptr_nxt = ptr_r;
    purged_nxt = purged_r;
    ev_nxt = ev_r;
    send_nxt = send_r;
    cmac_nxt = cmac_r;
    wr_en = 1'b0;
    wr_idx = pidx;
    wr_addr = mac_r;
    wr_seen = now_r;
    wr_gate = pay_r;
    wr_ack = 1'b0;
    sh_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ev_nxt = EV_NONE;
          send_nxt = 1'b0;
          cmac_nxt = '0;
          purged_nxt = '0;
          case (in_tuser)
            REQ_PKT: begin
              ptr_nxt = '0;
              state_nxt = ST_SCAN;
            end
            REQ_TICK: begin
              ptr_nxt = total_r;
              state_nxt = ST_PURGE;
            end
            default: state_nxt = ST_LEVEL;
          endcase
        end
      end
      ST_SCAN: begin
        if (len_r != PacketBytes) begin
          ev_nxt = EV_BAD_LEN;
          state_nxt = ST_OUT;
        end else if (ptr_r < total_r && addr_mem[pidx] == mac_r) begin
          if (kind_r == KIND_ANNOUNCE) begin
            wr_en = 1'b1;
            wr_addr = addr_mem[pidx];
            wr_ack = ack_mem[pidx];
            ev_nxt = EV_REFRESH;
          end else if (kind_r == KIND_ACK) begin
            wr_en = 1'b1;
            wr_addr = addr_mem[pidx];
            wr_seen = seen_mem[pidx];
            wr_ack = 1'b1;
            ev_nxt = EV_ACK;
          end
          state_nxt = ST_OUT;
        end else if (ptr_r < total_r) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          if (kind_r == KIND_ANNOUNCE) begin
            if (total_r >= CntW'(MaxPeers)) begin
              ev_nxt = EV_FULL;
            end else begin
              wr_en = 1'b1;
              wr_idx = total_r[IdxW-1:0];
              total_nxt = total_r + 1'b1;
              if (pick_r == -4'sd1) pick_nxt = '0;
              ev_nxt = EV_NEW;
            end
          end
          state_nxt = ST_OUT;
        end
      end
      ST_PURGE: begin
        if (ptr_r == '0) begin
          if (purged_r != '0) ev_nxt = EV_PURGED;
          state_nxt = ST_LEVEL;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
          if (stale) begin
            sh_en = 1'b1;
            total_nxt = total_r - 1'b1;
            purged_nxt = purged_r + 1'b1;
            if (pick_r == $signed({1'b0, didx}))
              pick_nxt = (total_r == 4'd1) ? -4'sd1 : 4'sd0;
            else if (pick_r > $signed({1'b0, didx}))
              pick_nxt = pick_r - 4'sd1;
          end
        end
      end
      ST_LEVEL: begin
        state_nxt = ST_OUT;
        if (req_r == REQ_BTN) begin
          if (pr_r && !btn_r) begin
            btn_nxt = 1'b1;
            press_nxt = now_r;
          end else if (!pr_r && btn_r) begin
            btn_nxt = 1'b0;
            if (held >= {16'd0, lp_r}) begin
              if (total_r != '0) begin
                pick_nxt = ({1'b0, pick_r[2:0]} + 4'd1 >= total_r || pick_r[3]) ?
                           4'sd0 : pick_r + 4'sd1;
                ev_nxt = EV_SEL_NEXT;
              end
            end else if (sel_ok) begin
              send_nxt = 1'b1;
              cmac_nxt = addr_mem[sidx];
              wr_en = 1'b1;
              wr_idx = sidx;
              wr_addr = addr_mem[sidx];
              wr_seen = seen_mem[sidx];
              wr_gate = gate_mem[sidx];
              wr_ack = 1'b0;
              ev_nxt = EV_CMD;
            end
          end
        end
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Checks on the sequencer and table bookkeeping
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(MaxPeers)) else $error("peer count over capacity");
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (total_r == '0 ? pick_r == -4'sd1 : sel_ok))
    else $error("selection out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_stale_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_v_r) else $error("result lost");
endmodule
`default_nettype wire

[design/pta_level.sv]
// Freshness level of one entry from its age and the timeout.
`default_nettype none
module pta_level
  import pta_pkg::*;
(
  input  wire  lvl_req_t req,
  output logic [2:0]     level
);
  logic [33:0] age4;
  logic [33:0] age2;
  logic [33:0] t1;
  logic [33:0] t3;

  // Compare scaled age against scaled timeout
  always_comb begin
    age4 = {req.age, 2'b00};
    age2 = {1'b0, req.age, 1'b0};
    t1 = {18'd0, req.tmo};
    t3 = {18'd0, req.tmo} + {17'd0, req.tmo, 1'b0};
    if ({2'b00, req.age} > t1) level = 3'd0;
    else if (age4 < t1) level = 3'd4;
    else if (age2 < t1) level = 3'd3;
    else if (age4 < t3) level = 3'd2;
    else level = 3'd1;
  end
endmodule
`default_nettype wire

[verif/peer_table_checker.sv]
// Checker: watches the peer table channels, predicts each result and compares.
`timescale 1ns / 100ps
module peer_table_checker
  import pta_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [135:0] in_tdata,
  input  wire  [1:0]   in_tuser,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [71:0]  out_tdata,
  input  wire          cfg_valid,
  input  wire          cfg_ready,
  input  wire  [0:0]   cfg_index,
  input  wire  [15:0]  cfg_data,
  output int           fail_count,
  output int           pending_results
);
  typedef struct packed {
    logic [2:0]  level;
    logic        acked;
    logic        gate_up;
    logic [3:0]  purged;
    logic [3:0]  count;
    logic [3:0]  sel;
    logic [1:0]  code;
    logic [47:0] mac;
    logic        send;
    logic [3:0]  ev;
  } peer_result_t;

  // Predictor state
  logic [47:0] tbl_addr [MaxPeers];
  logic [31:0] tbl_seen [MaxPeers];
  logic [31:0] tbl_gate [MaxPeers];
  logic        tbl_ack  [MaxPeers];
  int          tbl_total;
  int          pick;
  logic        btn_down;
  logic [31:0] press_start;
  logic [15:0] tmo_ms;
  logic [15:0] long_ms;
  peer_result_t result_queue[$];

  assign pending_results = result_queue.size();

  function automatic logic [2:0] freshness(logic [31:0] now, int idx);
    logic [33:0] age;
    logic [33:0] t;
    age = {2'b0, now - tbl_seen[idx]};
    t = {18'b0, tmo_ms};
    if (age > t) return 3'd0;
    if (4 * age < t) return 3'd4;
    if (2 * age < t) return 3'd3;
    if (4 * age < 3 * t) return 3'd2;
    return 3'd1;
  endfunction

  task automatic drop_entry(int i);
    for (int j = i; j + 1 < tbl_total; j++) begin
      tbl_addr[j] = tbl_addr[j+1];
      tbl_seen[j] = tbl_seen[j+1];
      tbl_gate[j] = tbl_gate[j+1];
      tbl_ack[j] = tbl_ack[j+1];
    end
    tbl_total--;
    if (pick == i) pick = (tbl_total == 0) ? -1 : 0;
    else if (pick > i) pick--;
  endtask

  task automatic predict_item(logic [1:0] req, logic [135:0] d);
    logic [31:0] now;
    logic [47:0] mac;
    logic [7:0]  len;
    logic [7:0]  kind;
    logic [31:0] pay;
    logic        pr;
    peer_result_t r;
    int idx;
    bit sel_ok;
    now = d[31:0]; mac = d[79:32]; len = d[87:80];
    kind = d[95:88]; pay = d[127:96]; pr = d[128];
    r = '0;
    r.ev = EV_NONE;
    if (req == REQ_PKT) begin
      if (len != PacketBytes) r.ev = EV_BAD_LEN;
      else begin
        idx = -1;
        for (int i = tbl_total - 1; i >= 0; i--) if (tbl_addr[i] == mac) idx = i;
        if (kind == KIND_ANNOUNCE) begin
          if (idx >= 0) begin
            tbl_seen[idx] = now; tbl_gate[idx] = pay; r.ev = EV_REFRESH;
          end else if (tbl_total >= MaxPeers) r.ev = EV_FULL;
          else begin
            tbl_addr[tbl_total] = mac; tbl_seen[tbl_total] = now;
            tbl_gate[tbl_total] = pay; tbl_ack[tbl_total] = 1'b0;
            tbl_total++;
            if (pick == -1) pick = 0;
            r.ev = EV_NEW;
          end
        end else if (kind == KIND_ACK && idx >= 0) begin
          tbl_ack[idx] = 1'b1; tbl_gate[idx] = pay; r.ev = EV_ACK;
        end
      end
    end else if (req == REQ_TICK) begin
      for (int i = tbl_total - 1; i >= 0; i--)
        if ((now - tbl_seen[i]) > {16'b0, tmo_ms}) begin
          drop_entry(i);
          r.purged++;
        end
      if (r.purged != 0) r.ev = EV_PURGED;
    end else if (req == REQ_BTN) begin
      if (pr && !btn_down) begin
        btn_down = 1'b1; press_start = now;
      end else if (!pr && btn_down) begin
        btn_down = 1'b0;
        if ((now - press_start) >= {16'b0, long_ms}) begin
          if (tbl_total > 0) begin
            pick = (pick + 1) % tbl_total; r.ev = EV_SEL_NEXT;
          end
        end else if (pick >= 0 && pick < tbl_total) begin
          r.send = 1'b1; r.mac = tbl_addr[pick]; r.code = CMD_FLIP;
          tbl_ack[pick] = 1'b0; r.ev = EV_CMD;
        end
      end
    end
    sel_ok = pick >= 0 && pick < tbl_total;
    r.sel = pick[3:0];
    r.count = tbl_total[3:0];
    r.gate_up = sel_ok && tbl_gate[pick] == 32'd1;
    r.acked = sel_ok && tbl_ack[pick];
    r.level = sel_ok ? freshness(now, pick) : 3'd0;
    result_queue = {result_queue, r};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Track configuration, predict on input beats, compare on output beats
  always @(posedge clk) begin
    peer_result_t g, w;
    if (!rst_n) begin
      tbl_total = 0; pick = -1; btn_down = 1'b0; press_start = '0;
      tmo_ms = TimeoutReset; long_ms = LongPressReset;
      result_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIMEOUT) tmo_ms = cfg_data;
        else long_ms = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        g = out_tdata;
        if (result_queue.size() == 0)
          report_mismatch("unexpected beat", out_tdata[63:0], 64'd0);
        else begin
          w = result_queue.pop_front();
          if (g.ev != w.ev) report_mismatch("event_res", 64'(g.ev), 64'(w.ev));
          if (g.send != w.send) report_mismatch("cmd_send", 64'(g.send), 64'(w.send));
          if (g.mac != w.mac) report_mismatch("cmd_mac", 64'(g.mac), 64'(w.mac));
          if (g.code != w.code) report_mismatch("cmd_code", 64'(g.code), 64'(w.code));
          if (g.sel != w.sel)
            report_mismatch("selected_index", 64'(g.sel), 64'(w.sel));
          if (g.count != w.count)
            report_mismatch("peer_count", 64'(g.count), 64'(w.count));
          if (g.purged != w.purged)
            report_mismatch("purged_count", 64'(g.purged), 64'(w.purged));
          if (g.gate_up != w.gate_up)
            report_mismatch("sel gate state", 64'(g.gate_up), 64'(w.gate_up));
          if (g.acked != w.acked)
            report_mismatch("sel_acked", 64'(g.acked), 64'(w.acked));
          if (g.level != w.level)
            report_mismatch("sel_signal_level", 64'(g.level), 64'(w.level));
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
  end
endmodule

[verif/testbench.sv]
// Testbench top: drives stimulus into the peer table core and gives the verdict.
`timescale 1ns / 100ps
module testbench;
  import pta_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           fail_count;
  int           pending_results;
  int           cycle_count = 0;
  bit           calm_phase = 1'b0;
  logic [31:0]  clock_ms = '0;
  logic [47:0]  mac_pool [12];

  localparam int CycleLimit = 400000;

  peer_table_with_aging_core uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  peer_table_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_results
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the receiver at random, except in the calm stretch
  always @(negedge clk) begin
    out_tready <= calm_phase || ($urandom_range(99) >= 20);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] req, logic [31:0] now, logic [47:0] mac,
                           logic [7:0] len, logic [7:0] kind, logic [31:0] pay,
                           logic pr);
    // Leave the previous deassert its own falling edge
    @(negedge clk);
    while (!calm_phase && $urandom_range(99) < 20) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'b0, pr, pay, kind, len, mac, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain_results();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int tmo);
    int sel;
    logic [7:0] len;
    logic [7:0] kind;
    logic [31:0] pay;
    clock_ms = clock_ms + $urandom_range(tmo / 3 + 1);
    sel = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? 8'($urandom) : PacketBytes;
    kind = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    pay = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1));
    if (sel < 50)
      send_beat(REQ_PKT, clock_ms, mac_pool[$urandom_range(11)], len, kind, pay, 1'b0);
    else if (sel < 65)
      send_beat(REQ_TICK, clock_ms, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                $urandom, 1'($urandom));
    else if (sel < 97)
      send_beat(REQ_BTN, clock_ms, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                $urandom, 1'($urandom));
    else
      send_beat(2'd3, $urandom, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                $urandom, 1'($urandom));
  endtask

  initial begin
    int tmo;
    for (int i = 0; i < 12; i++) mac_pool[i] = {$urandom, $urandom};
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: announces up to full, refresh, ack, bad length, other kinds
    for (int i = 0; i < 9; i++)
      send_beat(REQ_PKT, 32'(i * 10), mac_pool[i], PacketBytes, KIND_ANNOUNCE,
                32'(i & 1), 1'b0);
    send_beat(REQ_PKT, 32'd100, mac_pool[0], PacketBytes, KIND_ANNOUNCE, 32'hFFFF_FFFF, 1'b0);
    send_beat(REQ_PKT, 32'd110, mac_pool[1], PacketBytes, KIND_ACK, 32'd1, 1'b0);
    send_beat(REQ_PKT, 32'd110, mac_pool[11], PacketBytes, KIND_ACK, 32'd1, 1'b0);
    send_beat(REQ_PKT, 32'd120, mac_pool[2], 8'hFF, KIND_ANNOUNCE, 32'd0, 1'b0);
    send_beat(REQ_PKT, 32'd120, mac_pool[2], PacketBytes, 8'd1, 32'd0, 1'b0);
    send_beat(REQ_PKT, 32'd120, mac_pool[2], PacketBytes, 8'hFF, 32'h8000_0000, 1'b0);
    // Short press, long press, level without edge
    send_beat(REQ_BTN, 32'd200, '0, '0, '0, '0, 1'b1);
    send_beat(REQ_BTN, 32'd210, '0, '0, '0, '0, 1'b1);
    send_beat(REQ_BTN, 32'd220, '0, '0, '0, '0, 1'b0);
    send_beat(REQ_BTN, 32'd300, '0, '0, '0, '0, 1'b1);
    send_beat(REQ_BTN, 32'd900, '0, '0, '0, '0, 1'b0);
    send_beat(REQ_BTN, 32'd950, '0, '0, '0, '0, 1'b0);
    // Tick with no removal, then wrap-around age removes everything
    send_beat(REQ_TICK, 32'd1000, '0, '0, '0, '0, 1'b0);
    send_beat(REQ_TICK, 32'hFFFF_FF00, '0, '0, '0, '0, 1'b0);
    // Empty-table presses and an unused request type
    send_beat(REQ_BTN, 32'd0, '0, '0, '0, '0, 1'b1);
    send_beat(REQ_BTN, 32'd5000, '0, '0, '0, '0, 1'b0);
    send_beat(2'd3, '1, '1, '1, '1, '1, 1'b1);

    // Random phases over several register settings
    clock_ms = 32'hFFF0_0000;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin tmo = 5000; end
        1: begin tmo = 1; write_reg(CFG_TIMEOUT, 16'd1); write_reg(CFG_LONG_PRESS, 16'd1); end
        2: begin tmo = 65535; write_reg(CFG_TIMEOUT, 16'hFFFF);
                 write_reg(CFG_LONG_PRESS, 16'hFFFF); end
        3: begin tmo = 37; write_reg(CFG_TIMEOUT, 16'd37); write_reg(CFG_LONG_PRESS, 16'd9); end
        4: begin tmo = 2000; write_reg(CFG_TIMEOUT, 16'd2000);
                 write_reg(CFG_LONG_PRESS, 16'($urandom)); end
        5: begin tmo = 1000; write_reg(CFG_TIMEOUT, 16'hAAAA & 16'h03FF | 16'd1);
                 write_reg(CFG_LONG_PRESS, 16'h5555); end
        default: begin tmo = 5000; write_reg(CFG_TIMEOUT, 16'd5000);
                       write_reg(CFG_LONG_PRESS, 16'd500); end
      endcase
      calm_phase = (ph == 3);
      for (int n = 0; n < 250; n++) begin
        random_item(tmo);
        if (n == 120) drain_results();
      end
    end
    calm_phase = 1'b0;

    drain_results();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[files.f]
design/pta_pkg.sv
design/pta_level.sv
design/peer_table_with_aging_core.sv
verif/peer_table_checker.sv
verif/testbench.sv
